/* hdl/trs_pkg.sv */
// ----------------------------------------------------------------------------
// trs_pkg: types and constants for the trs model matrix builder
// input and result transaction structs, angle constants and atan table
// ----------------------------------------------------------------------------
package trs_pkg;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] angle_x;
    logic signed [31:0] angle_y;
    logic signed [31:0] angle_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
    logic signed [31:0] pivot_x;
    logic signed [31:0] pivot_y;
    logic signed [31:0] pivot_z;
  } trs_in_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] col0;
    logic signed [31:0] col1;
    logic signed [31:0] col2;
    logic signed [31:0] col3;
    logic               last_row;
  } trs_out_t;

  // angles with 30 fraction bits
  localparam logic signed [35:0] ANG_PI      = 36'sd3373259426;
  localparam logic signed [35:0] ANG_HALF_PI = 36'sd1686629713;
  localparam logic signed [35:0] ANG_TWO_PI  = 36'sd6746518852;
  localparam logic signed [35:0] CORDIC_GAIN = 36'sd652032874;
  localparam int ANG_TABLE_LEN = 30;

  // cordic state for one axis
  typedef struct packed {
    logic signed [35:0] x;
    logic signed [35:0] y;
    logic signed [35:0] z;
    logic               neg;
  } trs_cord_t;

  function automatic logic signed [35:0] atan_lut(input logic [4:0] i);
    logic signed [35:0] v;
    case (i)
      5'd0: v = 36'sd843314857;
      5'd1: v = 36'sd497837829;
      5'd2: v = 36'sd263043837;
      5'd3: v = 36'sd133525159;
      5'd4: v = 36'sd67021687;
      5'd5: v = 36'sd33543516;
      5'd6: v = 36'sd16775851;
      5'd7: v = 36'sd8388437;
      5'd8: v = 36'sd4194283;
      5'd9: v = 36'sd2097149;
      default: v = 36'sd1 <<< (5'd30 - i);
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

/* hdl/trs_transform_matrix_build_core.sv */
// ----------------------------------------------------------------------------
// trs_transform_matrix_build_core: trs model matrix builder with pivot
// builds T(pos)*T(pivot)*Rz*Ry*Rx*S*T(-pivot) and emits four row transactions
// pipeline stages: angle reduce (5), NCELL cordic cells, round (1), matrix math (5),
// row load (1); row 0 is presented from the row load registers,
// rows 1..3 follow on the next cycles
// accept pacing: busy rises after each accept and holds off the next one, so the
// shared row emitter sends all four rows of an item; items overlap in the pipeline
// reset: synchronous active low, clears valid pipeline and phase counter
// ----------------------------------------------------------------------------
module trs_transform_matrix_build_core import trs_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  trs_in_t  in_data,
  output logic     out_valid,
  output trs_out_t out_data
);
  localparam int NCELL = (CORDIC_STEPS < ANG_TABLE_LEN) ? CORDIC_STEPS : ANG_TABLE_LEN;
  localparam int RSH   = 30 - FRAC_BITS;
  localparam int DLY   = NCELL + 6;

  // modulo 2*pi by reciprocal multiplication
  localparam logic [63:0] TWO_PI_U  = 64'(ANG_TWO_PI);
  localparam logic [35:0] TWO_PI_M  = 36'(ANG_TWO_PI);
  localparam logic [29:0] RECIP_2PI = 30'((64'd1 << 62) / TWO_PI_U);
  localparam int          QSH       = 62 - RSH;

  logic signed [31:0] one32;
  assign one32 = 32'sd1 <<< FRAC_BITS;

  // accept pacing: a new item is accepted only while busy is low
  logic [1:0] gap_r;
  logic [1:0] gap_nxt;
  logic acc;
  assign busy = (gap_r != 2'd0);
  assign acc  = start && !busy;
  assign gap_nxt = acc ? 2'd3 : (busy ? gap_r - 2'd1 : 2'd0);

  // angle reduction, 5 stages: quotient estimate, remainder, correction
  // with sign, fold into [-pi, pi], fold into [-pi/2, pi/2]
  logic [31:0]        am_r  [3];
  logic               ng1_r [3];
  logic               ng2_r [3];
  logic [61:0]        qp_r  [3];
  logic [35:0]        rm_r  [3];
  logic signed [35:0] za_r  [3];
  logic signed [35:0] zb_r  [3];
  trs_cord_t          c0_r  [3];
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      logic signed [31:0] ang;
      logic [31:0]        mag;
      logic [21:0]        qe;
      logic [35:0]        rc;
      logic signed [35:0] z;
      case (a)
        0: ang = in_data.angle_x;
        1: ang = in_data.angle_y;
        default: ang = in_data.angle_z;
      endcase
      mag = ang[31] ? $unsigned(-ang) : $unsigned(ang);
      am_r[a]  <= mag;
      ng1_r[a] <= ang[31];
      qp_r[a]  <= 62'(mag) * 62'(RECIP_2PI);
      // quotient estimate is never high and at most one low
      qe = 22'(qp_r[a] >> QSH);
      rm_r[a]  <= 36'((64'(am_r[a]) << RSH) - 64'(qe) * TWO_PI_U);
      ng2_r[a] <= ng1_r[a];
      // remainder takes the sign of the angle
      rc = (rm_r[a] >= TWO_PI_M) ? rm_r[a] - TWO_PI_M : rm_r[a];
      za_r[a] <= ng2_r[a] ? -$signed(rc) : $signed(rc);
      z = za_r[a];
      if (z > ANG_PI) z = z - ANG_TWO_PI;
      else if (z < -ANG_PI) z = z + ANG_TWO_PI;
      zb_r[a] <= z;
      c0_r[a].x <= CORDIC_GAIN;
      c0_r[a].y <= '0;
      if (zb_r[a] > ANG_HALF_PI) begin
        c0_r[a].z <= zb_r[a] - ANG_PI; c0_r[a].neg <= 1'b1;
      end else if (zb_r[a] < -ANG_HALF_PI) begin
        c0_r[a].z <= zb_r[a] + ANG_PI; c0_r[a].neg <= 1'b1;
      end else begin
        c0_r[a].z <= zb_r[a]; c0_r[a].neg <= 1'b0;
      end
    end
  end

  // chain of cordic cells per axis
  trs_cord_t ch [3][NCELL+1];
  for (genvar a = 0; a < 3; a++) begin : g_ax
    assign ch[a][0] = c0_r[a];
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
      trs_cordic_cell #(.STEP(k)) u_cell (
        .clk(clk), .cell_in(ch[a][k]), .cell_out(ch[a][k+1]));
    end
  end

  // item fields delayed alongside the cordic
  trs_in_t dl_r [DLY];
  always_ff @(posedge clk) begin
    dl_r[0] <= in_data;
    for (int k = 1; k < DLY; k++) dl_r[k] <= dl_r[k-1];
  end

  // sine/cosine rounding
  logic signed [31:0] cs_r [3];
  logic signed [31:0] sn_r [3];
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      logic signed [35:0] x, y;
      x = ch[a][NCELL].neg ? -ch[a][NCELL].x : ch[a][NCELL].x;
      y = ch[a][NCELL].neg ? -ch[a][NCELL].y : ch[a][NCELL].y;
      cs_r[a] <= 32'((x + (36'sd1 <<< (RSH-1))) >>> RSH);
      sn_r[a] <= 32'((y + (36'sd1 <<< (RSH-1))) >>> RSH);
    end
  end

  function automatic logic signed [63:0] rnd(input logic signed [63:0] v);
    return (v + (64'sd1 <<< (FRAC_BITS-1))) >>> FRAC_BITS;
  endfunction

  // Q = Ry*Rx, then R = Rz*Q
  logic signed [31:0] q_r [3][3];
  logic signed [31:0] r_r [3][3];
  logic signed [63:0] a_r [3][3];
  logic signed [31:0] as_r [3][3];
  logic signed [63:0] t_r [3];
  logic signed [31:0] rz_r [3][3];
  trs_in_t  m1_r, m2_r, m3_r, m4_r;
  logic signed [31:0] rx [3][3], ry [3][3], rz [3][3];
  always_comb begin
    rx[0][0]=one32; rx[0][1]='0; rx[0][2]='0;
    rx[1][0]='0; rx[1][1]=cs_r[0]; rx[1][2]=sn_r[0];
    rx[2][0]='0; rx[2][1]=-sn_r[0]; rx[2][2]=cs_r[0];
    ry[0][0]=cs_r[1]; ry[0][1]='0; ry[0][2]=-sn_r[1];
    ry[1][0]='0; ry[1][1]=one32; ry[1][2]='0;
    ry[2][0]=sn_r[1]; ry[2][1]='0; ry[2][2]=cs_r[1];
    rz[0][0]=cs_r[2]; rz[0][1]=sn_r[2]; rz[0][2]='0;
    rz[1][0]=-sn_r[2]; rz[1][1]=cs_r[2]; rz[1][2]='0;
    rz[2][0]='0; rz[2][1]='0; rz[2][2]=one32;
  end
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        q_r[i][j] <= 32'(rnd(64'(ry[i][0])*64'(rx[0][j]) + 64'(ry[i][1])*64'(rx[1][j])
                             + 64'(ry[i][2])*64'(rx[2][j])));
  end
  always_ff @(posedge clk) begin
    rz_r <= rz;
    m1_r <= dl_r[DLY-1];
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        r_r[i][j] <= 32'(rnd(64'(rz_r[i][0])*64'(q_r[0][j]) + 64'(rz_r[i][1])*64'(q_r[1][j])
                             + 64'(rz_r[i][2])*64'(q_r[2][j])));
    m2_r <= m1_r;
    for (int i = 0; i < 3; i++) begin
      a_r[i][0] <= rnd(64'(r_r[i][0]) * 64'(m2_r.scale_x));
      a_r[i][1] <= rnd(64'(r_r[i][1]) * 64'(m2_r.scale_y));
      a_r[i][2] <= rnd(64'(r_r[i][2]) * 64'(m2_r.scale_z));
    end
    m3_r <= m2_r;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) as_r[i][j] <= sat32(a_r[i][j]);
    m4_r <= m3_r;
    t_r[0] <= 64'(m4_r.pos_x) + 64'(m4_r.pivot_x) - rnd(64'(as_r[0][0])*64'(m4_r.pivot_x))
              - rnd(64'(as_r[0][1])*64'(m4_r.pivot_y)) - rnd(64'(as_r[0][2])*64'(m4_r.pivot_z));
    t_r[1] <= 64'(m4_r.pos_y) + 64'(m4_r.pivot_y) - rnd(64'(as_r[1][0])*64'(m4_r.pivot_x))
              - rnd(64'(as_r[1][1])*64'(m4_r.pivot_y)) - rnd(64'(as_r[1][2])*64'(m4_r.pivot_z));
    t_r[2] <= 64'(m4_r.pos_z) + 64'(m4_r.pivot_z) - rnd(64'(as_r[2][0])*64'(m4_r.pivot_x))
              - rnd(64'(as_r[2][1])*64'(m4_r.pivot_y)) - rnd(64'(as_r[2][2])*64'(m4_r.pivot_z));
  end
  logic signed [31:0] af_r [3][3];
  always_ff @(posedge clk) af_r <= as_r;

  // valid pipeline to the row emitter: DLY + 5 stages
  localparam int VL = DLY + 5;
  logic [VL-1:0] vp_r;
  logic [1:0]    row_r;
  logic          emit_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= '0; vp_r <= '0; row_r <= '0; emit_r <= 1'b0;
    end else begin
      gap_r <= gap_nxt;
      vp_r  <= {vp_r[VL-2:0], acc};
      if (vp_r[VL-1]) begin
        emit_r <= 1'b1; row_r <= 2'd0;
      end else if (emit_r && row_r != 2'd3) begin
        row_r <= row_r + 2'd1;
      end else begin
        emit_r <= 1'b0;
      end
    end
  end

  // hold the finished matrix for its four row transactions
  logic signed [31:0] h_r [3][3];
  logic signed [31:0] ht_r [3];
  always_ff @(posedge clk) begin
    if (vp_r[VL-1]) begin
      h_r <= af_r;
      for (int i = 0; i < 3; i++) ht_r[i] <= sat32(t_r[i]);
    end
  end

  assign out_valid = emit_r;
  always_comb begin
    out_data.row_index = row_r;
    out_data.last_row  = (row_r == 2'd3);
    if (row_r == 2'd3) begin
      out_data.col0 = '0; out_data.col1 = '0; out_data.col2 = '0;
      out_data.col3 = one32;
    end else begin
      out_data.col0 = h_r[row_r][0];
      out_data.col1 = h_r[row_r][1];
      out_data.col2 = h_r[row_r][2];
      out_data.col3 = ht_r[row_r];
    end
  end
endmodule

/* hdl/trs_cordic_cell.sv */
// ----------------------------------------------------------------------------
// trs_cordic_cell: one cordic micro-rotation stage
// rotates one axis by a fixed step and hands the result to the next cell
// ----------------------------------------------------------------------------
module trs_cordic_cell import trs_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic      clk,
  input  trs_cord_t cell_in,
  output trs_cord_t cell_out
);
  trs_cord_t cell_nxt;
  localparam logic signed [35:0] ATAN = atan_lut(5'(STEP));

  always_comb begin
    cell_nxt = cell_in;
    if (!cell_in.z[35]) begin
      cell_nxt.x = cell_in.x - (cell_in.y >>> STEP);
      cell_nxt.y = cell_in.y + (cell_in.x >>> STEP);
      cell_nxt.z = cell_in.z - ATAN;
    end else begin
      cell_nxt.x = cell_in.x + (cell_in.y >>> STEP);
      cell_nxt.y = cell_in.y - (cell_in.x >>> STEP);
      cell_nxt.z = cell_in.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    cell_out <= cell_nxt;
  end
endmodule

/* hdl/trs_checker.sv */
// ----------------------------------------------------------------------------
// trs_checker: port-level checks for the trs matrix builder
// row order, last flag and accept pacing
// ----------------------------------------------------------------------------
module trs_checker import trs_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input trs_out_t out_data
);
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_row == (out_data.row_index == 2'd3)))
    else $error("last_row mismatch");
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.row_index != 2'd3 |=> out_valid &&
    out_data.row_index == $past(out_data.row_index) + 2'd1)
    else $error("row sequence broken");
  a_pace: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accept not paced");
endmodule

bind trs_transform_matrix_build_core trs_checker u_trs_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_data(out_data));
